// File: design/prm7_pkg.sv
// Shared widths and reset constants for the degree-7 polynomial remainder block.
package prm7_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned REM_W  = 7;

    // Generator reset value 0xD0 without its implied x^7 term.
    localparam logic [REM_W-1:0] GEN_LOW_RESET = 7'h50;

    typedef logic [REM_W-1:0]  rem_t;
    typedef logic [BYTE_W-1:0] byte_t;

endpackage

// File: design/prm7_divider.sv
// Eight unrolled shift-and-reduce steps that fold one message byte into the remainder.
module prm7_divider (
    input  prm7_pkg::rem_t  rem_in,
    input  prm7_pkg::byte_t data_in,
    input  prm7_pkg::rem_t  poly_low,
    output prm7_pkg::rem_t  rem_out
);

    always_comb begin
        prm7_pkg::rem_t rem_v;
        logic           carry;
        rem_v = rem_in;
        for (int i = prm7_pkg::BYTE_W - 1; i >= 0; i--) begin
            // The bit shifted out of x^6 is the x^7 coefficient; the leading
            // generator term always cancels it, leaving only the low terms.
            carry = rem_v[prm7_pkg::REM_W-1];
            rem_v = {rem_v[prm7_pkg::REM_W-2:0], data_in[i]};
            if (carry) begin
                rem_v = rem_v ^ poly_low;
            end
        end
        rem_out = rem_v;
    end

endmodule

// File: design/poly_remainder_mod_g7.sv
// Top level: running remainder of a byte stream modulo a configurable degree-7 generator.
//
//   channel | direction | handshake            | payload
//   s_      | in        | s_valid / s_ready    | s_data_byte[7:0], s_last_byte
//   m_      | out       | m_valid / m_ready    | m_remainder[6:0]
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_data[7:0] (generator)
//
// One item per clock unless a last item waits for a stalled result register. An
// accepted item sits in the input register, where the eight reduction steps run
// against the running remainder; a last item moves on into the result register
// once that is free, any other item only updates the remainder.
// Reset (synchronous, active low) clears the remainder, empties both registers
// and loads generator 0xD0. A stalled result register holds back only last items.
module poly_remainder_mod_g7 (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_last_byte,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_remainder,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    prm7_pkg::rem_t  poly_low_reg;
    prm7_pkg::rem_t  running_rem_reg;
    prm7_pkg::rem_t  running_rem_next;
    prm7_pkg::rem_t  rem_calc;

    logic            in_valid_reg;
    prm7_pkg::byte_t in_data_reg;
    logic            in_last_reg;

    logic            out_valid_reg;
    prm7_pkg::rem_t  out_rem_reg;

    logic            out_free;
    logic            in_advance;

    assign cfg_ready = 1'b1;

    assign out_free   = !out_valid_reg || m_ready;
    // Only a last item needs room in the result register.
    assign in_advance = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready    = !in_valid_reg || in_advance;

    assign m_valid     = out_valid_reg;
    assign m_remainder = out_rem_reg;

    prm7_divider u_divider (
        .rem_in   (running_rem_reg),
        .data_in  (in_data_reg),
        .poly_low (poly_low_reg),
        .rem_out  (rem_calc)
    );

    always_comb begin
        running_rem_next = running_rem_reg;
        if (in_advance) begin
            running_rem_next = in_last_reg ? '0 : rem_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_low_reg    <= prm7_pkg::GEN_LOW_RESET;
            running_rem_reg <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                poly_low_reg <= cfg_data[prm7_pkg::REM_W-1:0];
            end
            running_rem_reg <= running_rem_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg && in_last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (out_free && in_valid_reg && in_last_reg) begin
            out_rem_reg <= rem_calc;
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_low_means_busy: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_ready)
    ) else $error("input stalled without a blocked last item");

    a_last_clears_remainder: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (in_advance && in_last_reg) |=> (running_rem_reg == '0)
    ) else $error("remainder not cleared after last item");

    a_result_from_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg)
    ) else $error("result raised without a last item");
`endif

endmodule
